FILE: hdl/position_frame_receiver_unit_macros.svh
// Assertion helpers shared by the position frame receiver.
`ifndef POSITION_FRAME_RECEIVER_UNIT_MACROS_SVH
`define POSITION_FRAME_RECEIVER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PFR_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define PFR_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define PFR_ASSERT_IMP(name, clk, rstn, ante, cons)
`define PFR_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/pfr_pkg.sv
`default_nettype none
package pfr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;

  // Only the first STORE_DEPTH payload bytes are kept.
  localparam int unsigned STORE_DEPTH = 25;
  localparam int unsigned STORE_AW    = 5;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_CW    = 3;

  localparam logic [1:0] KIND_GOOD = 2'd0;
  localparam logic [1:0] KIND_LEN  = 2'd1;
  localparam logic [1:0] KIND_CKS  = 2'd2;

  localparam logic [1:0] CFG_OWN_ADDR   = 2'd0;
  localparam logic [1:0] CFG_BCAST_ADDR = 2'd1;
  localparam logic [1:0] CFG_CMD_CODE   = 2'd2;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_LEN_ERR,
    CMD_GOOD,
    CMD_CKS_ERR
  } pfr_cmd_e;

  typedef struct packed {
    pfr_cmd_e              cmd;
    logic [7:0]            data;
    logic [STORE_AW-1:0]   addr;
  } pfr_entry_t;

  typedef struct packed {
    logic [7:0] own_addr;
    logic [7:0] bcast_addr;
    logic [7:0] cmd_code;
  } pfr_cfg_t;

endpackage
`default_nettype wire

FILE: hdl/pfr_intf.sv
`default_nettype none
interface pfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface pfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface pfr_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [31:0] current_x;
  logic signed [31:0] current_y;
  logic signed [31:0] current_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic [7:0]         status_flags;
  logic [31:0]        good_frames;
  logic [31:0]        length_errors;
  logic [31:0]        checksum_errors;
  modport source (
    output valid, output result_kind, output current_x, output current_y,
    output current_z, output target_x, output target_y, output target_z,
    output status_flags, output good_frames, output length_errors,
    output checksum_errors, input ready
  );
  modport sink (
    input valid, input result_kind, input current_x, input current_y,
    input current_z, input target_x, input target_y, input target_z,
    input status_flags, input good_frames, input length_errors,
    input checksum_errors, output ready
  );
endinterface
`default_nettype wire

FILE: hdl/pfr_front.sv
`default_nettype none
module pfr_front
  import pfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 25
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire pfr_cfg_t   cfg_i,
  output logic            push_o,
  output pfr_entry_t      entry_o
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SUM  = 3'd5;
  localparam logic [2:0] PH_ADD  = 3'd6;

  localparam logic [7:0] LEN_BYTE = 8'(PAYLOAD_BYTES);
  localparam logic [5:0] LAST_POS = 6'(PAYLOAD_BYTES - 1);
  localparam logic [5:0] KEEP_POS = 6'(STORE_DEPTH);

  logic [2:0] phase_q, phase_d;
  logic [5:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] add_q, add_d;
  logic [7:0] rsum_q, rsum_d;
  logic [7:0] sum_abs;
  logic [7:0] add_abs;

  assign sum_abs = sum_q + rx_byte_i;
  assign add_abs = add_q + sum_abs;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    sum_d   = sum_q;
    add_d   = add_q;
    rsum_d  = rsum_q;
    push_o  = 1'b0;
    entry_o.cmd  = CMD_STORE;
    entry_o.data = rx_byte_i;
    entry_o.addr = pos_q[STORE_AW-1:0];
    if (accept_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == SYNC_BYTE) begin
            // Checksums restart with the sync byte itself.
            sum_d   = rx_byte_i;
            add_d   = rx_byte_i;
            pos_d   = '0;
            phase_d = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (rx_byte_i == cfg_i.own_addr || rx_byte_i == cfg_i.bcast_addr) begin
            sum_d   = sum_abs;
            add_d   = add_abs;
            phase_d = PH_CMD;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_CMD: begin
          if (rx_byte_i == cfg_i.cmd_code) begin
            sum_d   = sum_abs;
            add_d   = add_abs;
            phase_d = PH_LEN;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          if (rx_byte_i == LEN_BYTE) begin
            sum_d   = sum_abs;
            add_d   = add_abs;
            pos_d   = '0;
            phase_d = PH_DATA;
          end else begin
            push_o      = 1'b1;
            entry_o.cmd = CMD_LEN_ERR;
            phase_d     = PH_HUNT;
          end
        end
        PH_DATA: begin
          sum_d = sum_abs;
          add_d = add_abs;
          // Bytes beyond the store only feed the checksums.
          push_o = (pos_q < KEEP_POS);
          pos_d  = pos_q + 6'd1;
          if (pos_q == LAST_POS) begin
            phase_d = PH_SUM;
          end
        end
        PH_SUM: begin
          rsum_d  = rx_byte_i;
          phase_d = PH_ADD;
        end
        PH_ADD: begin
          push_o = 1'b1;
          if (rsum_q == sum_q && rx_byte_i == add_q) begin
            entry_o.cmd = CMD_GOOD;
          end else begin
            entry_o.cmd = CMD_CKS_ERR;
          end
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      sum_q   <= '0;
      add_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      add_q   <= add_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsum_q <= rsum_d;
  end

endmodule
`default_nettype wire

FILE: hdl/pfr_queue.sv
`default_nettype none
module pfr_queue
  import pfr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire pfr_entry_t entry_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      head_valid_o,
  output pfr_entry_t head_o
);

  pfr_entry_t          slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0] count_q;
  logic                do_pop;

  assign full_o       = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + QUEUE_CW'(1);
      end else if (do_pop && !push_i) begin
        count_q <= count_q - QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pfr_back.sv
`default_nettype none
module pfr_back
  import pfr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   head_valid_i,
  input  wire pfr_entry_t head_i,
  output logic        pop_o,
  pfr_res_if.source   res_o
);

  logic [7:0]  store_q [STORE_DEPTH];
  logic        out_valid_q;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] pos_q [6];
  logic [7:0]  flags_q;
  logic [31:0] good_q, good_d;
  logic [31:0] len_q, len_d;
  logic [31:0] cks_q, cks_d;
  logic        out_free;
  logic        is_result;
  logic        load;

  assign out_free  = !out_valid_q || res_o.ready;
  assign is_result = (head_i.cmd != CMD_STORE);
  assign pop_o     = head_valid_i && (!is_result || out_free);
  assign load      = pop_o && is_result;

  always_comb begin
    kind_d = KIND_GOOD;
    good_d = good_q;
    len_d  = len_q;
    cks_d  = cks_q;
    case (head_i.cmd)
      CMD_LEN_ERR: begin
        kind_d = KIND_LEN;
        len_d  = len_q + 32'd1;
      end
      CMD_CKS_ERR: begin
        kind_d = KIND_CKS;
        cks_d  = cks_q + 32'd1;
      end
      default: begin
        good_d = good_q + 32'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      good_q      <= '0;
      len_q       <= '0;
      cks_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        good_q      <= good_d;
        len_q       <= len_d;
        cks_q       <= cks_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !is_result) begin
      store_q[head_i.addr] <= head_i.data;
    end
    if (load) begin
      kind_q <= kind_d;
      // Error results carry zero positions and flags.
      for (int i = 0; i < 6; i++) begin
        pos_q[i] <= (head_i.cmd == CMD_GOOD) ?
                    {store_q[4*i+3], store_q[4*i+2], store_q[4*i+1], store_q[4*i]} :
                    32'd0;
      end
      flags_q <= (head_i.cmd == CMD_GOOD) ? store_q[24] : 8'd0;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.result_kind     = kind_q;
  assign res_o.current_x       = pos_q[0];
  assign res_o.current_y       = pos_q[1];
  assign res_o.current_z       = pos_q[2];
  assign res_o.target_x        = pos_q[3];
  assign res_o.target_y        = pos_q[4];
  assign res_o.target_z        = pos_q[5];
  assign res_o.status_flags    = flags_q;
  assign res_o.good_frames     = good_q;
  assign res_o.length_errors   = len_q;
  assign res_o.checksum_errors = cks_q;

endmodule
`default_nettype wire

FILE: hdl/position_frame_receiver_unit.sv
// Position frame receiver.
// rx_i carries one serial byte per beat; the unit hunts for a sync byte,
// checks address, command and length, keeps running sum and add checksums
// and collects the payload. res_o gives one result beat per frame whose
// address and command match: a valid frame with six positions and flags,
// a length error or a checksum error, each with the three running counters.
// cfg_i writes own address, broadcast address and command code by index; it
// is always ready and should only be used while no frame is in flight.
// Throughput is one byte per cycle while the queue has room. The entry for
// the byte that completes or rejects a frame goes into the four-entry queue
// between the byte parser and the result stage, which loads it into the
// result register. A stall on res_o holds the result; the parser keeps
// taking bytes until the queue fills, then drops rx_i.ready.
// Reset returns the parser to hunting, clears the counters and restores the
// register defaults (own address 0, broadcast 255, command 245).
`default_nettype none
`include "position_frame_receiver_unit_macros.svh"
module position_frame_receiver_unit
  import pfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 25
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pfr_rx_if.sink    rx_i,
  pfr_cfg_if.sink   cfg_i,
  pfr_res_if.source res_o
);

  pfr_cfg_t   cfg_q;
  logic       rx_accept;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       head_valid;
  pfr_entry_t front_entry;
  pfr_entry_t head;

  assign cfg_i.ready = 1'b1;
  assign rx_i.ready  = !q_full;
  assign rx_accept   = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_addr   <= 8'd0;
      cfg_q.bcast_addr <= 8'd255;
      cfg_q.cmd_code   <= 8'd245;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_OWN_ADDR:   cfg_q.own_addr   <= cfg_i.data;
        CFG_BCAST_ADDR: cfg_q.bcast_addr <= cfg_i.data;
        CFG_CMD_CODE:   cfg_q.cmd_code   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  pfr_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (rx_accept),
    .rx_byte_i (rx_i.rx_byte),
    .cfg_i     (cfg_q),
    .push_o    (q_push),
    .entry_o   (front_entry)
  );

  pfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .entry_i      (front_entry),
    .pop_i        (q_pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  pfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (q_pop),
    .res_o        (res_o)
  );

  `PFR_ASSERT_IMP(a_push_has_room, clk_i, rst_ni, q_push, !q_full)
  `PFR_ASSERT_IMP(a_pop_has_entry, clk_i, rst_ni, q_pop, head_valid)
  `PFR_ASSERT_NXT(a_good_reaches_out, clk_i, rst_ni, q_pop && head.cmd == CMD_GOOD, res_o.valid && res_o.result_kind == KIND_GOOD)
  `PFR_ASSERT_IMP(a_error_fields_zero, clk_i, rst_ni, res_o.valid && res_o.result_kind != KIND_GOOD, res_o.current_x == 32'sd0 && res_o.target_z == 32'sd0 && res_o.status_flags == 8'd0)

endmodule
`default_nettype wire

FILE: test/pfr_frame_checker.sv
`timescale 1ns / 1ps
module pfr_frame_checker
  import pfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 25
) (
  input  logic clk_i,
  input  logic rst_ni,
  pfr_rx_if    rx_mon,
  pfr_cfg_if   cfg_mon,
  pfr_res_if   res_mon,
  output int   mismatch_count_o,
  output int   pending_o
);

  typedef enum logic [2:0] {
    HUNT_SYNC,
    TAKE_ADDR,
    TAKE_CMD,
    TAKE_LEN,
    TAKE_DATA,
    TAKE_SUM,
    TAKE_ADD
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] cur_x;
    logic [31:0] cur_y;
    logic [31:0] cur_z;
    logic [31:0] tgt_x;
    logic [31:0] tgt_y;
    logic [31:0] tgt_z;
    logic [7:0]  flags;
    logic [31:0] good_total;
    logic [31:0] len_err_total;
    logic [31:0] cks_err_total;
  } frame_result_t;

  frame_result_t expected_results[$];

  logic [7:0]   own_addr;
  logic [7:0]   bcast_addr;
  logic [7:0]   cmd_code;
  parse_phase_e phase;
  logic [5:0]   byte_pos;
  logic [7:0]   run_sum;
  logic [7:0]   run_add;
  logic [7:0]   sum_byte;
  logic [7:0]   payload_copy [STORE_DEPTH];
  logic [31:0]  good_count;
  logic [31:0]  len_err_count;
  logic [31:0]  cks_err_count;

  function automatic logic [31:0] le_word(input int unsigned at);
    return {payload_copy[at + 3], payload_copy[at + 2], payload_copy[at + 1], payload_copy[at]};
  endfunction

  task automatic push_result(input logic [1:0] kind);
    frame_result_t r;
    r = '0;
    r.kind = kind;
    // Error results carry zero positions and flags.
    if (kind == KIND_GOOD) begin
      r.cur_x = le_word(0);
      r.cur_y = le_word(4);
      r.cur_z = le_word(8);
      r.tgt_x = le_word(12);
      r.tgt_y = le_word(16);
      r.tgt_z = le_word(20);
      r.flags = payload_copy[24];
    end
    r.good_total    = good_count;
    r.len_err_total = len_err_count;
    r.cks_err_total = cks_err_count;
    expected_results.push_back(r);
  endtask

  task automatic absorb(input logic [7:0] b);
    run_sum = run_sum + b;
    run_add = run_add + run_sum;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    case (phase)
      HUNT_SYNC: begin
        if (b == SYNC_BYTE) begin
          run_sum  = '0;
          run_add  = '0;
          absorb(b);
          byte_pos = '0;
          phase    = TAKE_ADDR;
        end
      end
      TAKE_ADDR: begin
        if (b == own_addr || b == bcast_addr) begin
          absorb(b);
          phase = TAKE_CMD;
        end else begin
          phase = HUNT_SYNC;
        end
      end
      TAKE_CMD: begin
        if (b == cmd_code) begin
          absorb(b);
          phase = TAKE_LEN;
        end else begin
          phase = HUNT_SYNC;
        end
      end
      TAKE_LEN: begin
        if (b == PAYLOAD_BYTES) begin
          absorb(b);
          byte_pos = '0;
          phase    = (PAYLOAD_BYTES == 0) ? TAKE_SUM : TAKE_DATA;
        end else begin
          len_err_count = len_err_count + 32'd1;
          phase         = HUNT_SYNC;
          push_result(KIND_LEN);
        end
      end
      TAKE_DATA: begin
        absorb(b);
        // Bytes beyond the store depth only enter the checksums.
        if (byte_pos < STORE_DEPTH) payload_copy[byte_pos] = b;
        byte_pos = byte_pos + 6'd1;
        if (byte_pos >= PAYLOAD_BYTES) phase = TAKE_SUM;
      end
      TAKE_SUM: begin
        sum_byte = b;
        phase    = TAKE_ADD;
      end
      TAKE_ADD: begin
        phase = HUNT_SYNC;
        if (sum_byte == run_sum && b == run_add) begin
          good_count = good_count + 32'd1;
          push_result(KIND_GOOD);
        end else begin
          cks_err_count = cks_err_count + 32'd1;
          push_result(KIND_CKS);
        end
      end
      default: phase = HUNT_SYNC;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count_o++;
    end
  endtask

  task automatic check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result beat with none expected, expected none, actual kind %h",
               $time, res_mon.result_kind);
      mismatch_count_o++;
    end else begin
      want = expected_results.pop_front();
      check_field("result_kind", want.kind, res_mon.result_kind);
      check_field("current_x", want.cur_x, res_mon.current_x);
      check_field("current_y", want.cur_y, res_mon.current_y);
      check_field("current_z", want.cur_z, res_mon.current_z);
      check_field("target_x", want.tgt_x, res_mon.target_x);
      check_field("target_y", want.tgt_y, res_mon.target_y);
      check_field("target_z", want.tgt_z, res_mon.target_z);
      check_field("status_flags", want.flags, res_mon.status_flags);
      check_field("good_frames", want.good_total, res_mon.good_frames);
      check_field("length_errors", want.len_err_total, res_mon.length_errors);
      check_field("checksum_errors", want.cks_err_total, res_mon.checksum_errors);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr      = 8'h00;
      bcast_addr    = 8'hFF;
      cmd_code      = 8'hF5;
      phase         = HUNT_SYNC;
      byte_pos      = '0;
      run_sum       = '0;
      run_add       = '0;
      sum_byte      = '0;
      good_count    = '0;
      len_err_count = '0;
      cks_err_count = '0;
      expected_results.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) check_result();
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_OWN_ADDR:   own_addr   = cfg_mon.data;
          CFG_BCAST_ADDR: bcast_addr = cfg_mon.data;
          CFG_CMD_CODE:   cmd_code   = cfg_mon.data;
          default: ;
        endcase
      end
      if (rx_mon.valid && rx_mon.ready) parse_byte(rx_mon.rx_byte);
    end
    pending_o = expected_results.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pfr_pkg::*;

  localparam int unsigned PAYLOAD_BYTES = 25;
  localparam logic [7:0]  LEN_BYTE        = 8'(PAYLOAD_BYTES);
  localparam logic [1:0]  CFG_SPARE       = 2'd3;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          ITEMS_PER_PHASE = 280;
  localparam int          PHASE_COUNT     = 5;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} stall_mode_e;
  typedef enum int {FRAME_CLEAN, FRAME_BAD_SUM, FRAME_BAD_ADD, FRAME_BAD_BOTH} frame_fault_e;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   pending_count;
  int   burst_left;
  int   frame_items;
  logic [7:0] own_addr;
  logic [7:0] bcast_addr;
  logic [7:0] cmd_code;
  logic [7:0] payload [PAYLOAD_BYTES];

  pfr_rx_if  rx_if ();
  pfr_cfg_if cfg_if ();
  pfr_res_if res_if ();

  position_frame_receiver_unit #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  pfr_frame_checker #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_mon          (rx_if),
    .cfg_mon         (cfg_if),
    .res_mon         (res_if),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("position_frame_receiver_unit test failed");
    $finish;
  end

  // The result side stalls in modes of its own, each held for a random stretch.
  initial begin : result_stalls
    stall_mode_e mode;
    int          hold;
    int          tick;
    res_if.ready = 1'b0;
    mode = RX_ALWAYS;
    hold = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        hold = $urandom_range(20, 200);
      end
      hold--;
      tick++;
      case (mode)
        RX_ALWAYS: res_if.ready = 1'b1;
        RX_COIN:   res_if.ready = 1'($urandom_range(0, 1));
        RX_SPARSE: res_if.ready = ($urandom_range(0, 7) == 0);
        default:   res_if.ready = tick[2];
      endcase
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'($urandom);
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Leaves valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    case (idx)
      CFG_OWN_ADDR:   own_addr   = data;
      CFG_BCAST_ADDR: bcast_addr = data;
      CFG_CMD_CODE:   cmd_code   = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] own, input logic [7:0] bcast,
                                input logic [7:0] cmd, input bit spare);
    write_reg(CFG_OWN_ADDR, own);
    write_reg(CFG_BCAST_ADDR, bcast);
    if (spare) write_reg(CFG_SPARE, 8'($urandom));
    write_reg(CFG_CMD_CODE, cmd);
    cfg_if.valid = 1'b0;
  endtask

  task automatic settle();
    rx_if.valid = 1'b0;
    burst_left  = 0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // From any parser state, 32 zero bytes finish or abandon the frame in
  // flight and leave the parser hunting, whatever the register settings.
  task automatic return_to_hunt();
    repeat (32) send_byte(8'h00);
  endtask

  function automatic logic [7:0] pick_addr();
    return ($urandom_range(0, 1) != 0) ? own_addr : bcast_addr;
  endfunction

  task automatic fill_payload();
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      case ($urandom_range(0, 15))
        0:       payload[i] = 8'h00;
        1:       payload[i] = 8'hFF;
        2:       payload[i] = SYNC_BYTE;
        3:       payload[i] = 8'h80;
        4:       payload[i] = 8'h7F;
        default: payload[i] = 8'($urandom);
      endcase
    end
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [7:0] len, input frame_fault_e fault);
    logic [7:0] hdr [4];
    logic [7:0] s;
    logic [7:0] a;
    hdr = '{SYNC_BYTE, addr, cmd, len};
    s = '0;
    a = '0;
    for (int i = 0; i < 4; i++) begin
      send_byte(hdr[i]);
      s = s + hdr[i];
      a = a + s;
    end
    frame_items += 4;
    if (len == LEN_BYTE) begin
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        send_byte(payload[i]);
        s = s + payload[i];
        a = a + s;
      end
      if (fault == FRAME_BAD_SUM || fault == FRAME_BAD_BOTH) s = s ^ 8'($urandom_range(1, 255));
      if (fault == FRAME_BAD_ADD || fault == FRAME_BAD_BOTH) a = a ^ 8'($urandom_range(1, 255));
      send_byte(s);
      send_byte(a);
      frame_items += PAYLOAD_BYTES + 2;
    end
  endtask

  task automatic send_bad_header();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 1) != 0) begin
      while (b == own_addr || b == bcast_addr) b = 8'($urandom);
      send_byte(SYNC_BYTE);
      send_byte(b);
      frame_items += 2;
    end else begin
      while (b == cmd_code) b = 8'($urandom);
      send_byte(SYNC_BYTE);
      send_byte(pick_addr());
      send_byte(b);
      frame_items += 3;
    end
  endtask

  task automatic random_traffic(input int target);
    int         start;
    int         pick;
    logic [7:0] len;
    start = frame_items;
    while (frame_items - start < target) begin
      pick = $urandom_range(0, 99);
      fill_payload();
      if (pick < 56) begin
        send_frame(pick_addr(), cmd_code, LEN_BYTE, FRAME_CLEAN);
      end else if (pick < 64) begin
        send_frame(pick_addr(), cmd_code, LEN_BYTE, FRAME_BAD_SUM);
      end else if (pick < 70) begin
        send_frame(pick_addr(), cmd_code, LEN_BYTE, FRAME_BAD_ADD);
      end else if (pick < 74) begin
        send_frame(pick_addr(), cmd_code, LEN_BYTE, FRAME_BAD_BOTH);
      end else if (pick < 82) begin
        do len = 8'($urandom); while (len == LEN_BYTE);
        send_frame(pick_addr(), cmd_code, len, FRAME_CLEAN);
      end else if (pick < 90) begin
        send_bad_header();
      end else begin
        pick = $urandom_range(1, 8);
        repeat (pick) send_byte(8'($urandom));
        frame_items += pick;
      end
    end
  endtask

  initial begin : stimulus
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_OWN_ADDR;
    cfg_if.data   = 8'h00;
    rst_ni        = 1'b0;
    burst_left    = 0;
    frame_items   = 0;
    own_addr      = 8'h00;
    bcast_addr    = 8'hFF;
    cmd_code      = 8'hF5;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Bad address, then a rejected sync byte in the address slot that must
    // not open a frame of its own.
    send_byte(SYNC_BYTE);
    send_byte(8'h01);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(own_addr);
    send_byte(cmd_code);
    send_byte(LEN_BYTE);
    // Bad command byte.
    send_byte(SYNC_BYTE);
    send_byte(bcast_addr);
    send_byte(~cmd_code);
    // Length byte errors at both extremes and either side of the payload size.
    send_frame(own_addr, cmd_code, 8'h00, FRAME_CLEAN);
    send_frame(bcast_addr, cmd_code, 8'hFF, FRAME_CLEAN);
    send_frame(own_addr, cmd_code, LEN_BYTE - 8'd1, FRAME_CLEAN);
    send_frame(bcast_addr, cmd_code, LEN_BYTE + 8'd1, FRAME_CLEAN);
    // Extreme positions and flags in a good frame, then a bad sum.
    payload = '{8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h01, 8'h00, 8'h00, 8'h00, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hFF};
    send_frame(own_addr, cmd_code, LEN_BYTE, FRAME_CLEAN);
    send_frame(bcast_addr, cmd_code, LEN_BYTE, FRAME_BAD_SUM);
    settle();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        1: apply_settings(8'hFF, 8'h00, 8'h00, 1'b0);
        2: apply_settings(SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, 1'b0);
        3: apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        4: apply_settings(8'h00, 8'hFF, 8'hFF, 1'b0);
        default: ;
      endcase
      if (p == 4) begin
        // Hold the sender back mid-phase until every result has drained.
        random_traffic(ITEMS_PER_PHASE / 2);
        settle();
        random_traffic(ITEMS_PER_PHASE / 2);
      end else begin
        random_traffic(ITEMS_PER_PHASE);
      end
      return_to_hunt();
      settle();
    end

    rx_if.valid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES * 3) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("position_frame_receiver_unit test passed");
    end else begin
      $display("position_frame_receiver_unit test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pfr_pkg.sv
hdl/pfr_intf.sv
hdl/pfr_front.sv
hdl/pfr_queue.sv
hdl/pfr_back.sv
hdl/position_frame_receiver_unit.sv
test/pfr_frame_checker.sv
test/tb_top.sv
